// File: src/skml_pkg.sv
`timescale 1ns / 1ps
package skml_pkg;
    localparam int TableDepthDef = 1024;
    localparam int HandleBitsDef = 16;
    localparam int MaxDepth      = 16384;

    typedef enum logic [1:0] {
        FN_CLEAR  = 2'd0,
        FN_APPEND = 2'd1,
        FN_FINISH = 2'd2,
        FN_QUERY  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_PHASE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_BUILDING = 2'd0,
        PH_FINISHED = 2'd1,
        PH_FAILED   = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_RD,     // read key[i]
        S_SORT_LD,     // latch key[i], read key[j-1]
        S_SORT_CMP,    // compare key[j-1] with held key
        S_SORT_PUT,    // write held pair to slot j
        S_CHK_RD,
        S_CHK_CMP,
        S_Q_RD,
        S_Q_CMP,
        S_Q_HND,
        S_OUT
    } t_state;
endpackage

// File: src/sorted_key_map_lookup.sv
`timescale 1ns / 1ps
// Sorted key map lookup: maps 32-bit ARGB keys to handles.
// Input word on s_axis: tdata = {handle_in, color_key}, tuser = func
//   (0 clear, 1 append, 2 finish, 3 query). One result word per input word
//   on m_axis: tdata = {entries_held, status, hit, handle_out}.
// i_cfg_we/i_cfg_wdata write the default handle returned on a query miss.
// One word is worked at a time; s_axis_tready is low while busy or while a
// result waits in the output register.
// Clear and append give their result directly; a query is a binary search
// whose probes one memory read port serialises. Finish is an insertion sort
// over the single read port and single write port, then a duplicate check
// over the sorted pairs.
// The next word is taken the cycle after the result is delivered.
// Reset empties the table (count zero, building phase) and the default
// handle becomes zero; memory contents are not cleared. A stalled m_axis
// holds the result, and no new word is taken until it is delivered.
module sorted_key_map_lookup
    import skml_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDef,
    parameter int HANDLE_BITS = HandleBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] color_key, [47:32] handle_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] handle_out, [16] hit,
                                        // [18:17] status, [29:19] entries_held
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int DW = (HANDLE_BITS > 16) ? 16 : HANDLE_BITS;

    logic [31:0]          r_kmem [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0] r_hmem [TABLE_DEPTH];
    logic [31:0]          r_krd;
    logic [HANDLE_BITS-1:0] r_hrd;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wkey;
    logic [HANDLE_BITS-1:0] mem_whnd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_kmem[mem_waddr] <= mem_wkey;
            r_hmem[mem_waddr] <= mem_whnd;
        end
        r_krd <= r_kmem[mem_raddr];
        r_hrd <= r_hmem[mem_raddr];
    end

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_lo, n_lo, r_hi, n_hi;
    logic [31:0]   r_key, n_key;
    logic [HANDLE_BITS-1:0] r_hnd, n_hnd;
    logic [15:0]   r_dflt;
    logic [31:0]   r_out, n_out;
    logic          r_ov, n_ov;
    logic [CW-1:0] mid;

    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_BUILDING;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_dflt  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (i_cfg_we) r_dflt <= i_cfg_wdata;
        end
        r_i <= n_i; r_j <= n_j; r_lo <= n_lo; r_hi <= n_hi;
        r_key <= n_key; r_hnd <= n_hnd; r_out <= n_out;
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    function automatic logic [31:0] pack(input logic [15:0] h, input logic ht,
                                         input t_status st, input logic [10:0] n);
        pack = {2'b00, n, st, ht, h};
    endfunction

    always_comb begin
        n_state = r_state; n_phase = r_phase; n_count = r_count;
        n_i = r_i; n_j = r_j; n_lo = r_lo; n_hi = r_hi;
        n_key = r_key; n_hnd = r_hnd; n_out = r_out;
        n_ov = r_ov && !m_axis_tready;
        mem_we = 1'b0; mem_waddr = '0; mem_raddr = '0;
        mem_wkey = r_key; mem_whnd = r_hnd;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_key = s_axis_tdata[31:0];
                    n_hnd = HANDLE_BITS'(s_axis_tdata[47:32]);
                    n_state = S_OUT;
                    unique case (t_func'(s_axis_tuser))
                        FN_CLEAR: begin
                            n_count = '0; n_phase = PH_BUILDING;
                            n_out = pack(16'd0, 1'b0, ST_OK, 11'd0);
                        end
                        FN_APPEND: begin
                            if (r_phase != PH_BUILDING)
                                n_out = pack(16'd0, 1'b0, ST_PHASE, 11'(r_count));
                            else if (r_count >= CW'(TABLE_DEPTH))
                                n_out = pack(16'd0, 1'b0, ST_FULL, 11'(r_count));
                            else begin
                                mem_we = 1'b1; mem_waddr = r_count[AW-1:0];
                                mem_wkey = s_axis_tdata[31:0];
                                mem_whnd = HANDLE_BITS'(s_axis_tdata[47:32]);
                                n_count = r_count + 1'b1;
                                n_out = pack(16'd0, 1'b0, ST_OK, 11'(r_count + 1'b1));
                            end
                        end
                        FN_FINISH: begin
                            if (r_phase != PH_BUILDING)
                                n_out = pack(16'd0, 1'b0, ST_PHASE, 11'(r_count));
                            else begin
                                n_i = CW'(1); n_state = S_SORT_RD;
                            end
                        end
                        FN_QUERY: begin
                            if (r_phase != PH_FINISHED)
                                n_out = pack(16'd0, 1'b0, ST_PHASE, 11'(r_count));
                            else begin
                                n_lo = '0; n_hi = r_count; n_state = S_Q_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SORT_RD: begin
                if (r_i >= r_count) begin
                    n_i = CW'(1); n_j = '0; n_state = S_CHK_RD;
                end else begin
                    mem_raddr = r_i[AW-1:0];
                    n_state = S_SORT_LD;
                end
            end
            S_SORT_LD: begin
                n_key = r_krd; n_hnd = r_hrd; n_j = r_i;
                mem_raddr = AW'(r_i - 1'b1);
                n_state = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                // shift larger neighbour up, then read the next one down
                if (r_j != '0 && r_krd > r_key) begin
                    mem_we = 1'b1; mem_waddr = r_j[AW-1:0];
                    mem_wkey = r_krd; mem_whnd = r_hrd;
                    n_j = r_j - 1'b1;
                    if (r_j == CW'(1)) n_state = S_SORT_PUT;
                    else begin
                        mem_raddr = AW'(r_j - 2'd2);
                        n_state = S_SORT_CMP;
                    end
                end else n_state = S_SORT_PUT;
            end
            S_SORT_PUT: begin
                mem_we = 1'b1; mem_waddr = r_j[AW-1:0];
                n_i = r_i + 1'b1; n_state = S_SORT_RD;
            end
            S_CHK_RD: begin
                if (r_i >= r_count) begin
                    n_phase = PH_FINISHED;
                    n_out = pack(16'd0, 1'b0, ST_OK, 11'(r_count));
                    n_state = S_OUT;
                end else begin
                    mem_raddr = AW'(r_i - 1'b1);
                    n_state = S_CHK_CMP;
                end
            end
            S_CHK_CMP: begin
                n_key = r_krd;
                mem_raddr = r_i[AW-1:0];
                // first visit holds key[i-1] and waits for key[i]; r_j flags the second visit
                if (r_j[0]) begin
                    n_j = '0;
                    if (r_krd == r_key) begin
                        n_phase = PH_FAILED;
                        n_out = pack(16'd0, 1'b0, ST_DUP, 11'(r_count));
                        n_state = S_OUT;
                    end else begin
                        n_i = r_i + 1'b1; n_state = S_CHK_RD;
                    end
                    n_key = r_key;
                end else begin
                    n_j = CW'(1);
                end
            end
            S_Q_RD: begin
                if (r_lo >= r_hi) begin
                    n_out = pack(16'(r_dflt[DW-1:0]), 1'b0, ST_OK, 11'(r_count));
                    n_state = S_OUT;
                end else begin
                    mem_raddr = mid[AW-1:0];
                    n_state = S_Q_CMP;
                end
            end
            S_Q_CMP: begin
                // keep the probe address so the handle is still there on a hit
                mem_raddr = mid[AW-1:0];
                if (r_krd == r_key) n_state = S_Q_HND;
                else begin
                    if (r_krd < r_key) n_lo = mid + 1'b1;
                    else n_hi = mid;
                    n_state = S_Q_RD;
                end
            end
            S_Q_HND: begin
                n_out = pack(16'(r_hrd), 1'b1, ST_OK, 11'(r_count));
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov) begin
                    n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import skml_pkg::*;

    typedef struct packed {
        logic [10:0] held;
        t_status     st;
        logic        hit;
        logic [15:0] hnd;
    } reply_t;

    class handle_map_model;
        logic [31:0] keys [1024];
        logic [15:0] hnds [1024];
        int          count;
        t_phase      phase;
        logic [15:0] dflt;
        reply_t      awaited_replies [$];
        int          errors;

        function new();
            count  = 0;
            phase  = PH_BUILDING;
            dflt   = '0;
            errors = 0;
        endfunction

        task report(string what);
            $display("%0t ERROR %s", $realtime, what);
            errors++;
        endtask

        // sorts held pairs by key, returns 1 on a repeated key
        function bit sort_pairs();
            int i;
            int j;
            logic [31:0] tk;
            logic [15:0] th;
            for (i = 1; i < count; i++) begin
                tk = keys[i];
                th = hnds[i];
                j = i;
                while (j > 0 && keys[j-1] > tk) begin
                    keys[j] = keys[j-1];
                    hnds[j] = hnds[j-1];
                    j--;
                end
                keys[j] = tk;
                hnds[j] = th;
            end
            for (i = 1; i < count; i++)
                if (keys[i] == keys[i-1]) return 1;
            return 0;
        endfunction

        function void note_word(t_func f, logic [31:0] k, logic [15:0] h);
            reply_t r;
            int lo;
            int hi;
            int mid;
            r = '0;
            r.st = ST_OK;
            case (f)
                FN_CLEAR: begin
                    count = 0;
                    phase = PH_BUILDING;
                end
                FN_APPEND: begin
                    if (phase != PH_BUILDING) r.st = ST_PHASE;
                    else if (count >= TableDepthDef) r.st = ST_FULL;
                    else begin
                        keys[count] = k;
                        hnds[count] = h;
                        count++;
                    end
                end
                FN_FINISH: begin
                    if (phase != PH_BUILDING) r.st = ST_PHASE;
                    else if (sort_pairs()) begin
                        r.st = ST_DUP;
                        phase = PH_FAILED;
                    end else phase = PH_FINISHED;
                end
                default: begin
                    if (phase != PH_FINISHED) r.st = ST_PHASE;
                    else begin
                        r.hnd = dflt;
                        lo = 0;
                        hi = count;
                        while (lo < hi) begin
                            mid = lo + (hi - lo) / 2;
                            if (keys[mid] == k) begin
                                r.hnd = hnds[mid];
                                r.hit = 1'b1;
                                break;
                            end
                            if (keys[mid] < k) lo = mid + 1;
                            else hi = mid;
                        end
                    end
                end
            endcase
            r.held = count[10:0];
            awaited_replies.push_back(r);
        endfunction

        task check_word(logic [31:0] d);
            reply_t e;
            reply_t g;
            g = reply_t'(d[29:0]);
            if (awaited_replies.size() == 0) begin
                report($sformatf("unexpected word %h", d));
            end else begin
                e = awaited_replies.pop_front();
                if (g.hnd !== e.hnd)
                    report($sformatf("handle_out %h, want %h", g.hnd, e.hnd));
                if (g.hit !== e.hit)
                    report($sformatf("hit %b, want %b", g.hit, e.hit));
                if (g.st !== e.st)
                    report($sformatf("status %0d, want %0d", g.st, e.st));
                if (g.held !== e.held)
                    report($sformatf("entries_held %0d, want %0d", g.held, e.held));
                if (d[31:30] !== 2'b00)
                    report($sformatf("pad bits %b", d[31:30]));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // [31:0] color_key, [47:32] handle_in
    logic [1:0]  s_axis_tuser = '0;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [15:0] handle_out, [16] hit, [18:17] status,
                                      // [29:19] entries_held
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req = 0;
    bit          hold_taken = 0;
    int          hold_left = 0;
    logic [31:0] used_keys [$];

    handle_map_model map_model = new();

    sorted_key_map_lookup i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            map_model.check_word(m_axis_tdata);
        if (hold_req && !hold_taken) begin
            hold_taken <= 1;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task send_word(t_func f, logic [31:0] k, logic [15:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {h, k};
        s_axis_tuser <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        map_model.note_word(f, k, h);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (map_model.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task write_default(logic [15:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        map_model.dflt = v;
        i_cfg_we <= 1'b0;
    endtask

    task noise_word();
        send_word(t_func'($urandom_range(3)), $urandom, 16'($urandom));
    endtask

    task query_some(int n);
        logic [31:0] k;
        repeat (n) begin
            if (used_keys.size() != 0 && $urandom_range(99) < 60)
                k = used_keys[$urandom_range(used_keys.size() - 1)];
            else k = $urandom;
            send_word(FN_QUERY, k, 16'($urandom));
        end
    endtask

    // clear, build a small table, usually finish, query; a little noise mixed in
    task table_session();
        int n;
        logic [31:0] k;
        bit dups;
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 24);
        dups = ($urandom_range(5) == 0);
        used_keys.delete();
        send_word(FN_CLEAR, $urandom, 16'($urandom));
        repeat (n) begin
            if (dups && used_keys.size() != 0 && $urandom_range(3) == 0)
                k = used_keys[$urandom_range(used_keys.size() - 1)];
            else k = $urandom;
            used_keys.push_back(k);
            send_word(FN_APPEND, k, 16'($urandom));
            if ($urandom_range(19) == 0) noise_word();
        end
        if ($urandom_range(19) != 0) send_word(FN_FINISH, $urandom, 16'($urandom));
        query_some($urandom_range(4, 24));
        if ($urandom_range(9) == 0) noise_word();
    endtask

    initial begin
        int p;
        int sent_goal;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: wrong phases, empty finish, extremes, duplicates, failed table
        send_word(FN_QUERY, 32'h0, 16'h0);
        send_word(FN_FINISH, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(FN_QUERY, 32'h1234_5678, 16'h0);
        send_word(FN_APPEND, 32'h1, 16'h1);
        send_word(FN_FINISH, 32'h0, 16'h0);
        send_word(FN_CLEAR, 32'h0, 16'h0);
        send_word(FN_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(FN_APPEND, 32'h0, 16'h0);
        send_word(FN_APPEND, 32'h0, 16'hAAAA);
        send_word(FN_FINISH, 32'h0, 16'h0);
        send_word(FN_QUERY, 32'h0, 16'h0);
        send_word(FN_APPEND, 32'h5, 16'h5);
        send_word(FN_FINISH, 32'h0, 16'h0);
        send_word(FN_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(FN_APPEND, 32'h8000_0000, 16'h5555);
        send_word(FN_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(FN_APPEND, 32'h0, 16'h0);
        send_word(FN_FINISH, 32'h0, 16'h0);
        send_word(FN_QUERY, 32'hFFFF_FFFF, 16'h0);
        send_word(FN_QUERY, 32'h0, 16'h0);
        send_word(FN_QUERY, 32'h7FFF_FFFF, 16'h0);
        send_word(FN_FINISH, 32'h0, 16'h0);
        write_default(16'hFFFF);
        send_word(FN_QUERY, 32'h7FFF_FFFF, 16'h0);

        // full table: ascending keys keep the sort short
        send_word(FN_CLEAR, 32'h0, 16'h0);
        for (int i = 0; i < TableDepthDef; i++)
            send_word(FN_APPEND, i * 32'h0040_0001 + 3, 16'($urandom));
        send_word(FN_APPEND, 32'hDEAD_BEEF, 16'h1234);
        send_word(FN_FINISH, 32'h0, 16'h0);
        used_keys.delete();
        used_keys.push_back(32'h3);
        used_keys.push_back(1023 * 32'h0040_0001 + 3);
        used_keys.push_back(512 * 32'h0040_0001 + 3);
        query_some(8);

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_default(16'h0); end
                1: begin
                    send_idle_pct = 62; recv_stall_pct = 0; write_default(16'($urandom));
                end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; write_default(16'hFFFF); end
                default: begin
                    send_idle_pct = 19; recv_stall_pct = 19; write_default(16'($urandom));
                end
            endcase
            sent_goal = 0;
            while (sent_goal < 3) begin
                if (p == 0 && sent_goal == 1) hold_req = 1;
                table_session();
                sent_goal++;
            end
        end

        drain();
        if (map_model.awaited_replies.size() != 0)
            map_model.report("results still awaited");
        if (map_model.errors == 0)
            $display("sorted_key_map_lookup: match");
        else
            $display("sorted_key_map_lookup: mismatch");
        $finish;
    end

    initial begin
        #40ms;
        $display("sorted_key_map_lookup: mismatch");
        $finish;
    end
endmodule

// File: files.f
src/skml_pkg.sv
src/sorted_key_map_lookup.sv
bench/testbench.sv
